>>> rtl/core/kpte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpte_pkg
// Shared constants, types and the field range check for the keypad clock
// field entry block.
// ----------------------------------------------------------------------------
package kpte_pkg;

   localparam int KEY_W   = 8;
   localparam int FIELD_W = 3;
   localparam int COUNT_W = 3;
   localparam int VALUE_W = 14;

   // Longest decimal entry that is kept; further digits are ignored.
   localparam logic [COUNT_W-1:0] MAX_DIGITS = 3'd4;

   localparam logic [KEY_W-1:0] KEY_EXIT  = 8'h41;
   localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_NEXT  = 8'h23;
   localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
   localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

   localparam logic [FIELD_W-1:0] FIELD_HOUR    = 3'd0;
   localparam logic [FIELD_W-1:0] FIELD_MINUTE  = 3'd1;
   localparam logic [FIELD_W-1:0] FIELD_SECOND  = 3'd2;
   localparam logic [FIELD_W-1:0] FIELD_DAY     = 3'd3;
   localparam logic [FIELD_W-1:0] FIELD_MONTH   = 3'd4;
   localparam logic [FIELD_W-1:0] FIELD_YEAR    = 3'd5;
   localparam logic [FIELD_W-1:0] FIELD_WEEKDAY = 3'd6;
   localparam logic [FIELD_W-1:0] LAST_FIELD    = FIELD_WEEKDAY;

   localparam logic [VALUE_W-1:0] HOUR_MAX    = 14'd23;
   localparam logic [VALUE_W-1:0] MINSEC_MAX  = 14'd59;
   localparam logic [VALUE_W-1:0] DAY_MAX     = 14'd31;
   localparam logic [VALUE_W-1:0] MONTH_MAX   = 14'd12;
   localparam logic [VALUE_W-1:0] YEAR_MIN    = 14'd2000;
   localparam logic [VALUE_W-1:0] WEEKDAY_MAX = 14'd6;
   localparam logic [VALUE_W-1:0] DECIMAL     = 14'd10;

   typedef struct packed {
      logic [FIELD_W-1:0] field;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] entry;
   } state_type;

   typedef struct packed {
      logic               write_strobe;
      logic [FIELD_W-1:0] write_field;
      logic [VALUE_W-1:0] write_value;
      logic               edit_done;
      state_type          after;
   } result_type;

   function automatic logic field_accepts(input logic [FIELD_W-1:0] field,
                                          input logic [VALUE_W-1:0] value);
      logic ok;
      unique case (field)
         FIELD_HOUR:    ok = (value <= HOUR_MAX);
         FIELD_MINUTE:  ok = (value <= MINSEC_MAX);
         FIELD_SECOND:  ok = (value <= MINSEC_MAX);
         FIELD_DAY:     ok = (value != '0) && (value <= DAY_MAX);
         FIELD_MONTH:   ok = (value != '0) && (value <= MONTH_MAX);
         FIELD_YEAR:    ok = (value >= YEAR_MIN);
         FIELD_WEEKDAY: ok = (value <= WEEKDAY_MAX);
         default:       ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage : kpte_pkg
`default_nettype wire

>>> rtl/core/kpte_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpte_step
// Decodes one key against the current edit state and forms the result word
// together with the state that follows it.
// ----------------------------------------------------------------------------
module kpte_step (
   input  wire logic [kpte_pkg::KEY_W-1:0] key_code,
   input  wire kpte_pkg::state_type        state_cur,
   output kpte_pkg::result_type            result
);
   import kpte_pkg::*;

   logic [KEY_W-1:0]   digit_raw;
   logic [VALUE_W-1:0] digit_value;

   assign digit_raw   = key_code - KEY_ZERO;
   assign digit_value = {{(VALUE_W-KEY_W){1'b0}}, digit_raw};

   always_comb begin
      result              = '0;
      result.after        = state_cur;
      priority if (key_code == KEY_EXIT) begin
         result.edit_done = 1'b1;
         result.after     = '0;
      end else if ((key_code >= KEY_ZERO) && (key_code <= KEY_NINE)) begin
         // A full entry swallows further digits unchanged.
         if (state_cur.count < MAX_DIGITS) begin
            result.after.entry = state_cur.entry * DECIMAL + digit_value;
            result.after.count = state_cur.count + 3'd1;
         end
      end else if (key_code == KEY_CLEAR) begin
         result.after.count = '0;
         result.after.entry = '0;
      end else if (key_code == KEY_NEXT) begin
         if ((state_cur.count != '0) && field_accepts(state_cur.field, state_cur.entry)) begin
            result.write_strobe = 1'b1;
            result.write_field  = state_cur.field;
            result.write_value  = state_cur.entry;
         end
         result.after.count = '0;
         result.after.entry = '0;
         if (state_cur.field >= LAST_FIELD) begin
            result.edit_done   = 1'b1;
            result.after.field = FIELD_HOUR;
         end else begin
            result.after.field = state_cur.field + 3'd1;
         end
      end else begin
         result.after = state_cur;
      end
   end

endmodule : kpte_step
`default_nettype wire

>>> rtl/core/keypad_time_field_entry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_time_field_entry
// Keypad entry of clock fields hour to weekday with range check and field write.
// ----------------------------------------------------------------------------
// Every key word accepted gives exactly one result word. A key is taken into
// an input register and, once the result register is free, decoded against
// the edit state and written to the result register, at the same edge as the
// edit state moves on. One key word is accepted in every cycle while results
// are taken, since the input register refills in the cycle that it passes its
// key on.
module keypad_time_field_entry (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] key_code
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [2:0] write_field, [16:3] write_value,
                                         // [19:17] field_after, [22:20] count_after,
                                         // [36:23] entry_after, [39:37] zero
   output logic             rsp_tuser,   // write_strobe
   output logic             rsp_tlast    // edit_done
);
   import kpte_pkg::*;

   logic             key_valid_ff, key_valid_in;
   logic [KEY_W-1:0] key_ff;
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;
   result_type       step_result;
   logic             rsp_free;
   logic             advance;

   kpte_step u_step (
      .key_code  (key_ff),
      .state_cur (state_ff),
      .result    (step_result)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign advance      = key_valid_ff && rsp_free;
   assign req_tready   = !key_valid_ff || advance;
   assign key_valid_in = (req_tvalid && req_tready) || (key_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign state_in     = advance ? step_result.after : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         key_valid_ff <= key_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         key_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.write_strobe;
   assign rsp_tlast  = rsp_ff.edit_done;
   assign rsp_tdata  = {3'b000, rsp_ff.after.entry, rsp_ff.after.count,
                        rsp_ff.after.field, rsp_ff.write_value, rsp_ff.write_field};

   // The entry never holds more digits than allowed and the field stays valid.
   a_state_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count <= MAX_DIGITS) && (state_ff.field <= LAST_FIELD))
      else $error("edit state out of range");

   // An empty entry always has value zero.
   a_empty_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count == '0) |-> (state_ff.entry == '0))
      else $error("empty entry with non-zero value");

   // A field write comes only from the confirm key, which clears the entry.
   a_write_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.write_strobe) |->
         ((rsp_ff.after.count == '0) && (rsp_ff.after.entry == '0)))
      else $error("field write without cleared entry");

   // Ending the edit returns to the hour field with nothing entered.
   a_done_home: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.edit_done) |->
         ((rsp_ff.after.field == FIELD_HOUR) && (rsp_ff.after.count == '0)))
      else $error("edit ended away from hour field");

endmodule : keypad_time_field_entry
`default_nettype wire
